// ===== hdl/assert_macros.svh =====
// assertion macros shared by the encoder step queue modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition must never hold outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`else

`define ASSERT_NEVER(label, cond)
`define ASSERT_IMPLY(label, ante, cons)

`endif

`endif

// ===== hdl/qenc_pkg.sv =====
// types, constants and helpers for the quadrature encoder step queue
// no dependencies
package qenc_pkg;

    localparam int ENCODER_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH_DEF   = 32;
    localparam int SEL_W             = 2;

    // class of an A-phase edge, keyed by B level and A direction
    typedef enum logic [2:0] {
        EDGE_NONE     = 3'd0,
        EDGE_BLO_RISE = 3'd1,
        EDGE_BLO_FALL = 3'd2,
        EDGE_BHI_RISE = 3'd3,
        EDGE_BHI_FALL = 3'd4
    } edge_class_t;

    // command from the front end to one lane
    typedef struct packed {
        logic sample;
        logic tick;
        logic level_a;
        logic level_b;
    } lane_cmd_t;

    // lane status back to the front end
    typedef struct packed {
        logic nonempty;
        logic head_cw;
    } lane_stat_t;

    // shared control from a lane to its row of cells
    typedef struct packed {
        logic pop;
        logic push_cw;
    } cell_ctl_t;

    function automatic edge_class_t class_edge(input logic b, input logic a);
        edge_class_t ev;
        if (!b)
        begin
            ev = a ? EDGE_BLO_RISE : EDGE_BLO_FALL;
        end
        else
        begin
            ev = a ? EDGE_BHI_RISE : EDGE_BHI_FALL;
        end
        return ev;
    endfunction

endpackage

// ===== hdl/qenc_if.sv =====
// valid/ready channel interfaces for request and response beats
// depends on qenc_pkg for the select width
interface qenc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [qenc_pkg::SEL_W-1:0] encoder_select;
    logic                       level_a;
    logic                       level_b;

    modport source (output valid, cmd, encoder_select, level_a, level_b, input ready);
    modport sink   (input valid, cmd, encoder_select, level_a, level_b, output ready);
endinterface

interface qenc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [qenc_pkg::SEL_W-1:0] encoder_id;
    logic                       cw_step;
    logic                       ccw_step;

    modport source (output valid, encoder_id, cw_step, ccw_step, input ready);
    modport sink   (input valid, encoder_id, cw_step, ccw_step, output ready);
endinterface

// ===== hdl/qenc_cell.sv =====
// one slot of a step queue: holds a single direction bit
// depends on qenc_pkg for the cell control struct
module qenc_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  qenc_pkg::cell_ctl_t ctl,
    input  logic                load,
    input  logic                upper_cw,
    output logic                step_cw
);

    logic step_cw_reg;
    logic step_cw_next;

    // pop takes the neighbor's bit, push loads the slot at the tail
    always_comb
    begin
        step_cw_next = step_cw_reg;
        if (ctl.pop)
        begin
            step_cw_next = upper_cw;
        end
        else if (load)
        begin
            step_cw_next = ctl.push_cw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cw_reg <= 1'b0;
        end
        else
        begin
            step_cw_reg <= step_cw_next;
        end
    end

    assign step_cw = step_cw_reg;

endmodule

// ===== hdl/qenc_lane.sv =====
// per-encoder lane: edge tracker, fill count and a row of queue cells
// depends on qenc_pkg, qenc_cell and assert_macros.svh
`include "assert_macros.svh"

module qenc_lane
#(
    parameter int QUEUE_DEPTH = qenc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qenc_pkg::lane_cmd_t  cmd,
    output qenc_pkg::lane_stat_t stat
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                   last_a_reg;
    logic                   last_a_next;
    qenc_pkg::edge_class_t  last_class_reg;
    qenc_pkg::edge_class_t  last_class_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    qenc_pkg::edge_class_t  ev;
    logic                   a_changed;
    logic                   want_cw;
    logic                   want_ccw;
    logic                   push;
    logic                   pop;
    logic                   not_full;
    qenc_pkg::cell_ctl_t    ctl;
    logic [QUEUE_DEPTH-1:0] cell_cw;

    // edge classing and step detection
    always_comb
    begin
        ev        = qenc_pkg::class_edge(cmd.level_b, cmd.level_a);
        a_changed = cmd.sample && (cmd.level_a != last_a_reg);
        want_cw   = (last_class_reg == qenc_pkg::EDGE_BLO_FALL)
                    && (ev == qenc_pkg::EDGE_BHI_RISE);
        want_ccw  = (last_class_reg == qenc_pkg::EDGE_BHI_FALL)
                    && (ev == qenc_pkg::EDGE_BLO_RISE);
        not_full  = count_reg < CNT_W'(QUEUE_DEPTH);
        push      = a_changed && (want_cw || want_ccw) && not_full;
        pop       = cmd.tick && (count_reg != '0);
        ctl.pop     = pop;
        ctl.push_cw = want_cw;
    end

    // state update
    always_comb
    begin
        last_a_next     = last_a_reg;
        last_class_next = last_class_reg;
        count_next      = count_reg;
        if (a_changed)
        begin
            last_a_next     = cmd.level_a;
            last_class_next = ev;
        end
        if (push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg     <= 1'b0;
            last_class_reg <= qenc_pkg::EDGE_NONE;
            count_reg      <= '0;
        end
        else
        begin
            last_a_reg     <= last_a_next;
            last_class_reg <= last_class_next;
            count_reg      <= count_next;
        end
    end

    // row of cells, head at index zero
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic upper;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign upper = 1'b0;
        end
        else
        begin : g_mid
            assign upper = cell_cw[i+1];
        end

        qenc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .load     (push && (count_reg == CNT_W'(i))),
            .upper_cw (upper),
            .step_cw  (cell_cw[i])
        );
    end

    assign stat.nonempty = count_reg != '0;
    assign stat.head_cw  = cell_cw[0];

    // checks
    `ASSERT_NEVER(a_count_range, count_reg > CNT_W'(QUEUE_DEPTH))
    `ASSERT_NEVER(a_push_pop_excl, push && pop)
    `ASSERT_IMPLY(a_class_tracks_a, last_class_reg != qenc_pkg::EDGE_NONE,
                  last_a_reg == (last_class_reg == qenc_pkg::EDGE_BLO_RISE
                                 || last_class_reg == qenc_pkg::EDGE_BHI_RISE))

endmodule

// ===== hdl/quadrature_encoder_step_queue.sv =====
// top level of the quadrature encoder step queue
// depends on qenc_pkg, qenc_if, qenc_lane and assert_macros.svh
//
// Usage:
//   req channel: each beat is either a phase-A sample (cmd 0) or a scan
//     tick (cmd 1) for the encoder named by encoder_select.
//   rsp channel: one beat per tick, carrying encoder_id and the popped
//     step as cw_step / ccw_step; both flags are low on an empty queue
//     or an encoder number beyond the configured count. Samples give none.
//   Throughput: one req beat per cycle while req.ready is high. Every item
//     updates its lane in the cycle it is accepted; each lane's queue is a
//     row of cells that shifts toward the head on a pop.
//   Response: a tick's rsp beat is registered in the output stage below.
//   Stall: a two-entry output stage (register plus skid) holds results;
//     the skid fills when a tick arrives while the register is full and
//     rsp.ready is low. req.ready is low while the skid is full and rises
//     the cycle after the next rsp beat.
//   Full queue: a new step is dropped, the edge is still recorded.
//   Reset: rst_n clears all edge history, fill counts and output beats;
//     the block accepts beats from the first cycle after reset.
`include "assert_macros.svh"

module quadrature_encoder_step_queue
#(
    parameter int ENCODER_COUNT = qenc_pkg::ENCODER_COUNT_DEF,
    parameter int QUEUE_DEPTH   = qenc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    qenc_req_if.sink   req,
    qenc_rsp_if.source rsp
);

    localparam int SEL_W = qenc_pkg::SEL_W;

    logic                 req_fire;
    logic                 tick_fire;
    logic                 rsp_fire;
    logic                 new_cw;
    qenc_pkg::lane_cmd_t  lane_cmd [ENCODER_COUNT];
    qenc_pkg::lane_stat_t lane_stat [ENCODER_COUNT];
    logic [ENCODER_COUNT-1:0] lane_hit;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SEL_W-1:0] out_id_reg;
    logic [SEL_W-1:0] out_id_next;
    logic             out_cw_reg;
    logic             out_cw_next;
    logic             out_ccw_reg;
    logic             out_ccw_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [SEL_W-1:0] skid_id_reg;
    logic [SEL_W-1:0] skid_id_next;
    logic             skid_cw_reg;
    logic             skid_cw_next;
    logic             skid_ccw_reg;
    logic             skid_ccw_next;

    assign req.ready = !skid_valid_reg;
    assign req_fire  = req.valid && req.ready;
    assign tick_fire = req_fire && req.cmd;
    assign rsp_fire  = out_valid_reg && rsp.ready;

    // fan the beat out to the addressed lane
    for (genvar e = 0; e < ENCODER_COUNT; e++)
    begin : g_lane
        assign lane_hit[e]          = req_fire && (32'(req.encoder_select) == e);
        assign lane_cmd[e].sample   = lane_hit[e] && !req.cmd;
        assign lane_cmd[e].tick     = lane_hit[e] && req.cmd;
        assign lane_cmd[e].level_a  = req.level_a;
        assign lane_cmd[e].level_b  = req.level_b;

        qenc_lane #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (lane_cmd[e]),
            .stat  (lane_stat[e])
        );
    end

    // addressed lane holds a step; zero when unaddressed or empty
    always_comb
    begin
        new_cw = 1'b0;
        for (int e = 0; e < ENCODER_COUNT; e++)
        begin
            new_cw = new_cw | (lane_hit[e] && lane_stat[e].nonempty);
        end
    end

    logic new_head;
    always_comb
    begin
        new_head = 1'b0;
        for (int e = 0; e < ENCODER_COUNT; e++)
        begin
            new_head = new_head
                       | (lane_hit[e] && lane_stat[e].nonempty && lane_stat[e].head_cw);
        end
    end

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_cw_next     = out_cw_reg;
        out_ccw_next    = out_ccw_reg;
        skid_valid_next = skid_valid_reg;
        skid_id_next    = skid_id_reg;
        skid_cw_next    = skid_cw_reg;
        skid_ccw_next   = skid_ccw_reg;
        if (skid_valid_reg)
        begin
            if (rsp_fire)
            begin
                out_id_next     = skid_id_reg;
                out_cw_next     = skid_cw_reg;
                out_ccw_next    = skid_ccw_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (tick_fire)
        begin
            if (!out_valid_reg || rsp_fire)
            begin
                out_valid_next = 1'b1;
                out_id_next    = req.encoder_select;
                out_cw_next    = new_head;
                out_ccw_next   = new_cw && !new_head;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_id_next    = req.encoder_select;
                skid_cw_next    = new_head;
                skid_ccw_next   = new_cw && !new_head;
            end
        end
        else if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_id_reg   <= out_id_next;
        out_cw_reg   <= out_cw_next;
        out_ccw_reg  <= out_ccw_next;
        skid_id_reg  <= skid_id_next;
        skid_cw_reg  <= skid_cw_next;
        skid_ccw_reg <= skid_ccw_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.encoder_id = out_id_reg;
    assign rsp.cw_step    = out_cw_reg;
    assign rsp.ccw_step   = out_ccw_reg;

    // checks
    `ASSERT_IMPLY(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_NEVER(a_flags_excl, out_valid_reg && out_cw_reg && out_ccw_reg)
    `ASSERT_IMPLY(a_rsp_from_tick, $rose(out_valid_reg), $past(tick_fire))

endmodule
